// ----- design/rmap_pkg.sv -----
package rmap_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = 26;

    localparam logic [7:0] PATH_LIMIT = 8'h20;
    localparam logic [7:0] PROTO_ID   = 8'h01;

    typedef enum logic [1:0] {
        KIND_PATH    = 2'd0,
        KIND_REPLY   = 2'd1,
        KIND_DATA    = 2'd2,
        KIND_SUMMARY = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_INCOMPLETE = 3'd1,
        ST_HDR_CRC    = 3'd2,
        ST_PROTOCOL   = 3'd3,
        ST_DATA_CRC   = 3'd4
    } status_t;

    // one result item as it leaves the front end
    typedef struct packed {
        kind_t       kind;
        logic [7:0]  obyte;
        logic [1:0]  ptype;
        logic [7:0]  tgt;
        logic [7:0]  ini;
        logic [7:0]  ins;
        logic [7:0]  key;
        logic [15:0] tid;
        logic [7:0]  ext;
        logic [31:0] addr;
        logic [23:0] len;
        status_t     st;
    } res_t;

    // RMAP CRC-8, reflected x^8+x^2+x+1
    function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] x;
        x = crc ^ b;
        for (int k = 0; k < 8; k++)
        begin
            x = x[0] ? ((x >> 1) ^ 8'hE0) : (x >> 1);
        end
        return x;
    endfunction

endpackage

// ----- design/rmap_front.sv -----
module rmap_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          take,
    input  logic [7:0]    char_byte,
    input  logic          is_end,
    output logic          res_valid,
    output rmap_pkg::res_t res
);

    logic                          phase_reg, phase_next;
    logic [rmap_pkg::CNT_W-1:0]    cnt_reg, cnt_next;
    logic [7:0]                    hcrc_reg, hcrc_next;
    logic [7:0]                    dcrc_reg, dcrc_next;
    logic [3:0]                    ralen_reg, ralen_next;
    logic                          nz_reg, nz_next;
    logic                          pok_reg, pok_next;
    logic [7:0][7:0]               slot_reg, slot_next;
    logic [31:0]                   addr_reg, addr_next;
    logic [23:0]                   len_reg, len_next;

    logic [7:0]                    instr;
    logic                          cmd;
    logic                          wr;
    logic [4:0]                    hlen;
    logic [4:0]                    hlen_old;
    logic [4:0]                    n5;
    logic [4:0]                    k5;
    logic [rmap_pkg::CNT_W-1:0]    n_ext_len;
    logic [rmap_pkg::CNT_W-1:0]    data_idx;
    logic                          cmd_old;
    logic                          wr_old;
    logic [1:0]                    ptype_old;
    rmap_pkg::status_t             st;

    // header decode from stored fields (summary) and with the live instruction byte
    always_comb
    begin
        cmd_old   = slot_reg[2][6];
        wr_old    = slot_reg[2][5];
        ptype_old = {cmd_old, wr_old};
        hlen_old  = cmd_old ? (5'd16 + {1'b0, ralen_reg}) : (wr_old ? 5'd8 : 5'd12);
        instr     = (cnt_reg == 26'd2) ? char_byte : slot_reg[2];
        cmd       = instr[6];
        wr        = instr[5];
        hlen      = cmd ? (5'd16 + ((cnt_reg == 26'd2) ? {1'b0, char_byte[1:0], 2'b00}
                                                      : {1'b0, ralen_reg}))
                        : (wr ? 5'd8 : 5'd12);
        n5        = cnt_reg[4:0];
        k5        = cmd ? (n5 - {1'b0, ralen_reg}) : n5;
        data_idx  = cnt_reg - {{(rmap_pkg::CNT_W-5){1'b0}}, hlen};
    end

    // end-of-packet status
    always_comb
    begin
        n_ext_len = {2'b00, len_reg};
        if (!phase_reg || cnt_reg < 26'd4)
            st = rmap_pkg::ST_INCOMPLETE;
        else if (ptype_old == 2'd0)
        begin
            if (cnt_reg < 26'd12)                  st = rmap_pkg::ST_INCOMPLETE;
            else if (hcrc_reg != 8'd0)             st = rmap_pkg::ST_HDR_CRC;
            else if (!pok_reg)                     st = rmap_pkg::ST_PROTOCOL;
            else if (cnt_reg != n_ext_len + 26'd13) st = rmap_pkg::ST_INCOMPLETE;
            else if (dcrc_reg != 8'd0)             st = rmap_pkg::ST_DATA_CRC;
            else                                   st = rmap_pkg::ST_OK;
        end
        else if (ptype_old == 2'd3)
        begin
            if (cnt_reg <= {21'd0, hlen_old})      st = rmap_pkg::ST_INCOMPLETE;
            else if (hcrc_reg != 8'd0)             st = rmap_pkg::ST_HDR_CRC;
            else if (!pok_reg)                     st = rmap_pkg::ST_PROTOCOL;
            else if (cnt_reg != n_ext_len + {21'd0, hlen_old} + 26'd1)
                                                   st = rmap_pkg::ST_INCOMPLETE;
            else if (dcrc_reg != 8'd0)             st = rmap_pkg::ST_DATA_CRC;
            else                                   st = rmap_pkg::ST_OK;
        end
        else
        begin
            if (cnt_reg != {21'd0, hlen_old})      st = rmap_pkg::ST_INCOMPLETE;
            else if (hcrc_reg != 8'd0)             st = rmap_pkg::ST_HDR_CRC;
            else if (!pok_reg)                     st = rmap_pkg::ST_PROTOCOL;
            else                                   st = rmap_pkg::ST_OK;
        end
    end

    // per-character classification and capture
    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        hcrc_next  = hcrc_reg;
        dcrc_next  = dcrc_reg;
        ralen_next = ralen_reg;
        nz_next    = nz_reg;
        pok_next   = pok_reg;
        slot_next  = slot_reg;
        addr_next  = addr_reg;
        len_next   = len_reg;
        res_valid  = 1'b0;
        res        = '0;
        res.kind   = rmap_pkg::KIND_PATH;
        res.st     = rmap_pkg::ST_OK;
        res.obyte  = char_byte;

        if (take)
        begin
            if (is_end)
            begin
                res_valid = 1'b1;
                res.kind  = rmap_pkg::KIND_SUMMARY;
                res.obyte = 8'd0;
                res.ptype = ptype_old;
                res.tgt   = cmd_old ? slot_reg[0] : slot_reg[4];
                res.ini   = cmd_old ? slot_reg[4] : slot_reg[0];
                res.ins   = slot_reg[2];
                res.key   = slot_reg[3];
                res.tid   = {slot_reg[5], slot_reg[6]};
                res.ext   = cmd_old ? slot_reg[7] : 8'd0;
                res.addr  = cmd_old ? addr_reg : 32'd0;
                res.len   = len_reg;
                res.st    = st;
                phase_next = 1'b0;
                cnt_next   = '0;
                hcrc_next  = 8'd0;
                dcrc_next  = 8'd0;
                ralen_next = 4'd0;
                nz_next    = 1'b0;
                pok_next   = 1'b1;
                slot_next  = '0;
                addr_next  = 32'd0;
                len_next   = 24'd0;
            end
            else if (!phase_reg && char_byte < rmap_pkg::PATH_LIMIT)
            begin
                res_valid = 1'b1;
            end
            else
            begin
                phase_next = 1'b1;
                if (cnt_reg == 26'd2)
                begin
                    slot_next[2] = char_byte;
                    ralen_next   = {char_byte[1:0], 2'b00};
                end
                if (cnt_reg < {21'd0, hlen})
                begin
                    hcrc_next = rmap_pkg::crc_step(hcrc_reg, char_byte);
                    if (cnt_reg == 26'd1)
                        pok_next = (char_byte == rmap_pkg::PROTO_ID);
                    if (cnt_reg < 26'd4)
                    begin
                        if (cnt_reg != 26'd2)
                            slot_next[n5[2:0]] = char_byte;
                    end
                    else if (cmd && n5 < 5'd4 + ralen_next)
                    begin
                        if (char_byte != 8'd0 || nz_reg)
                        begin
                            nz_next   = 1'b1;
                            res_valid = 1'b1;
                            res.kind  = rmap_pkg::KIND_REPLY;
                        end
                    end
                    else if (k5 <= 5'd6)
                        slot_next[k5[2:0]] = char_byte;
                    else if (cmd)
                    begin
                        if (k5 == 5'd7)
                            slot_next[7] = char_byte;
                        else if (k5 <= 5'd11)
                            addr_next = {addr_reg[23:0], char_byte};
                        else if (k5 <= 5'd14)
                            len_next = {len_reg[15:0], char_byte};
                    end
                    else if (!wr && k5 >= 5'd8 && k5 <= 5'd10)
                        len_next = {len_reg[15:0], char_byte};
                end
                else
                begin
                    dcrc_next = rmap_pkg::crc_step(dcrc_reg, char_byte);
                    if (cmd == wr && data_idx < {2'b00, len_reg})
                    begin
                        res_valid = 1'b1;
                        res.kind  = rmap_pkg::KIND_DATA;
                    end
                end
                if (cnt_reg != '1)
                    cnt_next = cnt_reg + 26'd1;
            end
        end
    end

    // packet state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 1'b0;
            cnt_reg   <= '0;
            hcrc_reg  <= 8'd0;
            dcrc_reg  <= 8'd0;
            ralen_reg <= 4'd0;
            nz_reg    <= 1'b0;
            pok_reg   <= 1'b1;
            slot_reg  <= '0;
            addr_reg  <= 32'd0;
            len_reg   <= 24'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            hcrc_reg  <= hcrc_next;
            dcrc_reg  <= dcrc_next;
            ralen_reg <= ralen_next;
            nz_reg    <= nz_next;
            pok_reg   <= pok_next;
            slot_reg  <= slot_next;
            addr_reg  <= addr_next;
            len_reg   <= len_next;
        end
    end

endmodule

// ----- design/rmap_queue.sv -----
module rmap_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  rmap_pkg::res_t push_data,
    output logic           room,
    output logic           head_valid,
    input  logic           pop,
    output rmap_pkg::res_t head
);

    rmap_pkg::res_t                  mem_reg [rmap_pkg::QUEUE_DEPTH];
    logic [rmap_pkg::QPTR_W-1:0]     wptr_reg;
    logic [rmap_pkg::QPTR_W-1:0]     rptr_reg;
    logic [rmap_pkg::QPTR_W:0]       cnt_reg;
    logic                            do_pop;

    assign room       = (cnt_reg != rmap_pkg::QUEUE_DEPTH[rmap_pkg::QPTR_W:0]);
    assign head_valid = (cnt_reg != '0);
    assign head       = mem_reg[rptr_reg];
    assign do_pop     = pop && head_valid;

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wptr_reg] <= push_data;
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (push)
                wptr_reg <= wptr_reg + 1'b1;
            if (do_pop)
                rptr_reg <= rptr_reg + 1'b1;
            if (push && !do_pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (!push && do_pop)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= rmap_pkg::QUEUE_DEPTH[rmap_pkg::QPTR_W:0])
        else $error("queue over depth");
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> room)
        else $error("push into full queue");
    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == '0) |-> (wptr_reg == rptr_reg))
        else $error("pointers disagree with empty queue");

endmodule

// ----- design/rmap_packet_parser_top.sv -----
// A result item enters the result queue at the character transfer and leaves from its head.
// Throughput: one character per cycle while the result queue has room; the front end
// classifies each character combinationally and the four-entry result queue lets it run
// while the output side stalls. Characters that cause no result only update parser state.
// Reset: rst_n asynchronous, active low; clears parser state and empties the queue.
module rmap_packet_parser_top (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // char_byte
    input  logic         s_tlast,   // is_end
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // out_byte, packet_type, target_logical,
                                    // initiator_logical, instruction_byte, key_or_status,
                                    // transaction_id, extended_address, memory_address,
                                    // data_length, status_code, zero pad
    output logic [1:0]   m_tuser    // item_kind
);

    logic           take;
    logic           res_valid;
    rmap_pkg::res_t res;
    rmap_pkg::res_t head;

    assign take = s_tvalid && s_tready;

    rmap_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .char_byte (s_tdata),
        .is_end    (s_tlast),
        .res_valid (res_valid),
        .res       (res)
    );

    rmap_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (res_valid),
        .push_data  (res),
        .room       (s_tready),
        .head_valid (m_tvalid),
        .pop        (m_tready),
        .head       (head)
    );

    // output packing, first field lowest
    assign m_tuser = head.kind;
    assign m_tdata = {3'd0, head.st, head.len, head.addr, head.ext, head.tid, head.key,
                      head.ins, head.ini, head.tgt, head.ptype, head.obyte};

endmodule

// ----- test/tb_rmap_packet_parser_top.sv -----
module tb_rmap_packet_parser_top;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [7:0]   s_tdata;    // char_byte
    logic         s_tlast;    // is_end
    logic         m_tvalid;
    logic         m_tready;
    logic [127:0] m_tdata;    // out_byte, packet_type, target_logical, initiator_logical,
                              // instruction_byte, key_or_status, transaction_id,
                              // extended_address, memory_address, data_length,
                              // status_code, zero pad
    logic [1:0]   m_tuser;    // item_kind

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_CHARS   = 1500;

    typedef struct {
        rmap_pkg::kind_t kind;
        logic [127:0]    data;
    } parse_out_t;

    typedef struct {
        logic [7:0]      b;
        logic            e;
        logic            chk;
        rmap_pkg::kind_t kind;
        logic [127:0]    data;
    } dir_row_t;

    parse_out_t pending_results[$];
    int         errors;
    int         idle_cycles = 0;
    int         chars_sent;
    int         rdy_hold;

    // predictor state
    logic        pr_in_hdr;
    logic [25:0] pr_count;
    logic [7:0]  pr_hcrc;
    logic [7:0]  pr_dcrc;
    logic [3:0]  pr_ralen;
    logic        pr_nz_seen;
    logic        pr_proto_ok;
    logic [7:0]  pr_fld [8];
    logic [31:0] pr_addr;
    logic [23:0] pr_len;

    rmap_packet_parser_top uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // RMAP CRC-8, reflected polynomial
    function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] x;
        x = crc ^ b;
        for (int i = 0; i < 8; i++)
        begin
            x = x[0] ? ((x >> 1) ^ 8'hE0) : (x >> 1);
        end
        return x;
    endfunction

    function automatic void clear_packet_state();
        pr_in_hdr   = 1'b0;
        pr_count    = '0;
        pr_hcrc     = '0;
        pr_dcrc     = '0;
        pr_ralen    = '0;
        pr_nz_seen  = 1'b0;
        pr_proto_ok = 1'b1;
        for (int i = 0; i < 8; i++)
        begin
            pr_fld[i] = '0;
        end
        pr_addr = '0;
        pr_len  = '0;
    endfunction

    function automatic void push_byte(input rmap_pkg::kind_t k, input logic [7:0] b);
        parse_out_t r;
        r.kind = k;
        r.data = {120'd0, b};
        pending_results.insert(pending_results.size(), r);
    endfunction

    // advance the parser model by one character
    function automatic void parse_char(input logic [7:0] b, input logic e);
        logic [7:0]        instr;
        logic              cmd;
        logic              wr;
        logic [1:0]        pt;
        int unsigned       hlen;
        int unsigned       n;
        int unsigned       k;
        rmap_pkg::status_t st;
        parse_out_t        r;
        instr = pr_fld[2];
        cmd   = instr[6];
        wr    = instr[5];
        pt    = {cmd, wr};
        hlen  = cmd ? 16 + pr_ralen : (wr ? 8 : 12);
        n     = pr_count;
        if (e)
        begin
            if (!pr_in_hdr || n < 4)
                st = rmap_pkg::ST_INCOMPLETE;
            else if (pt == 2'd0)
            begin
                if (n < 12) st = rmap_pkg::ST_INCOMPLETE;
                else if (pr_hcrc != 0) st = rmap_pkg::ST_HDR_CRC;
                else if (!pr_proto_ok) st = rmap_pkg::ST_PROTOCOL;
                else if (n != 13 + pr_len) st = rmap_pkg::ST_INCOMPLETE;
                else if (pr_dcrc != 0) st = rmap_pkg::ST_DATA_CRC;
                else st = rmap_pkg::ST_OK;
            end
            else if (pt == 2'd3)
            begin
                if (n <= hlen) st = rmap_pkg::ST_INCOMPLETE;
                else if (pr_hcrc != 0) st = rmap_pkg::ST_HDR_CRC;
                else if (!pr_proto_ok) st = rmap_pkg::ST_PROTOCOL;
                else if (n != hlen + pr_len + 1) st = rmap_pkg::ST_INCOMPLETE;
                else if (pr_dcrc != 0) st = rmap_pkg::ST_DATA_CRC;
                else st = rmap_pkg::ST_OK;
            end
            else
            begin
                if (n != hlen) st = rmap_pkg::ST_INCOMPLETE;
                else if (pr_hcrc != 0) st = rmap_pkg::ST_HDR_CRC;
                else if (!pr_proto_ok) st = rmap_pkg::ST_PROTOCOL;
                else st = rmap_pkg::ST_OK;
            end
            r.kind = rmap_pkg::KIND_SUMMARY;
            r.data = {3'd0, st, pr_len, (cmd ? pr_addr : 32'd0), (cmd ? pr_fld[7] : 8'd0),
                      pr_fld[5], pr_fld[6], pr_fld[3], instr,
                      (cmd ? pr_fld[4] : pr_fld[0]), (cmd ? pr_fld[0] : pr_fld[4]),
                      pt, 8'd0};
            pending_results.insert(pending_results.size(), r);
            clear_packet_state();
            return;
        end

        // path prefix
        if (!pr_in_hdr && b < rmap_pkg::PATH_LIMIT)
        begin
            push_byte(rmap_pkg::KIND_PATH, b);
            return;
        end
        pr_in_hdr = 1'b1;

        if (n == 2)
        begin
            pr_fld[2] = b;
            pr_ralen  = {b[1:0], 2'b00};
            cmd  = b[6];
            wr   = b[5];
            hlen = cmd ? 16 + pr_ralen : (wr ? 8 : 12);
        end

        if (n < hlen)
        begin
            pr_hcrc = crc8_next(pr_hcrc, b);
            if (n == 1)
                pr_proto_ok = (b == rmap_pkg::PROTO_ID);
            if (n < 4)
            begin
                if (n != 2)
                    pr_fld[n] = b;
            end
            else if (cmd && n < 4 + pr_ralen)
            begin
                // reply address, leading zeros dropped
                if (b != 0 || pr_nz_seen)
                begin
                    pr_nz_seen = 1'b1;
                    push_byte(rmap_pkg::KIND_REPLY, b);
                end
            end
            else
            begin
                k = cmd ? n - pr_ralen : n;
                if (k <= 6)
                    pr_fld[k] = b;
                else if (cmd)
                begin
                    if (k == 7)
                        pr_fld[7] = b;
                    else if (k <= 11)
                        pr_addr = {pr_addr[23:0], b};
                    else if (k <= 14)
                        pr_len = {pr_len[15:0], b};
                end
                else if (!wr && k >= 8 && k <= 10)
                    pr_len = {pr_len[15:0], b};
            end
        end
        else
        begin
            pr_dcrc = crc8_next(pr_dcrc, b);
            if (cmd == wr && (n - hlen) < pr_len)
                push_byte(rmap_pkg::KIND_DATA, b);
        end

        if (pr_count != '1)
            pr_count = pr_count + 1'b1;
    endfunction

    // clock
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #10 clk = ~clk;
        end
    end

    // output side: random stall before each result
    always @(posedge clk or negedge rst_n)
    begin
        int wait_draw;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            rdy_hold <= $urandom_range(0, 16);
        end
        else if (m_tvalid && m_tready)
        begin
            wait_draw = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 16));
            rdy_hold <= wait_draw;
            m_tready <= (wait_draw == 0);
        end
        else if (rdy_hold > 0)
        begin
            rdy_hold <= rdy_hold - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // result check
    always @(posedge clk)
    begin
        parse_out_t r;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result kind=%0d data=%h", $time, m_tuser, m_tdata);
                errors++;
            end
            else
            begin
                r = pending_results.pop_front();
                if (m_tuser !== r.kind)
                begin
                    $display("%0t: item_kind expected %0d actual %0d", $time, r.kind, m_tuser);
                    errors++;
                end
                if (m_tdata !== r.data)
                begin
                    $display("%0t: tdata expected %h actual %h", $time, r.data, m_tdata);
                    errors++;
                end
            end
        end
    end

    // watchdog on transfer activity
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // one character transfer, then predict
    task automatic send_char(input logic [7:0] b, input logic e, input int gap);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= e;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        parse_char(b, e);
        chars_sent++;
    endtask

    function automatic int draw_gap(input bit burst);
        return burst ? 0 : $urandom_range(0, 16);
    endfunction

    // build and send one packet, well formed or damaged
    task automatic send_packet(input bit burst);
        logic [7:0] pkt[$];
        logic [7:0] crc;
        logic [7:0] instr;
        logic       cmd;
        logic       wr;
        int         ral;
        int         dlen;
        int         dmg;
        int         pos;
        int         npath;
        npath = $urandom_range(0, 3);
        dmg   = $urandom_range(0, 11);
        if (dmg == 11)
        begin
            // noise
            repeat ($urandom_range(0, 20)) pkt.insert(pkt.size(), 8'($urandom_range(0, 255)));
        end
        else
        begin
            cmd   = 1'($urandom_range(0, 1));
            wr    = 1'($urandom_range(0, 1));
            instr = 8'($urandom_range(0, 255));
            instr[6] = cmd;
            instr[5] = wr;
            ral   = cmd ? 4 * instr[1:0] : 0;
            dlen  = (cmd == wr) ? $urandom_range(0, 8) : $urandom_range(0, 16777215);
            pkt.insert(pkt.size(), 8'($urandom_range(32, 255)));
            pkt.insert(pkt.size(), rmap_pkg::PROTO_ID);
            pkt.insert(pkt.size(), instr);
            pkt.insert(pkt.size(), 8'($urandom_range(0, 255)));
            if (cmd)
            begin
                for (int i = 0; i < ral; i++)
                    pkt.insert(pkt.size(),
                               $urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(0, 255)));
                repeat (8) pkt.insert(pkt.size(), 8'($urandom_range(0, 255)));
                pkt.insert(pkt.size(), dlen[23:16]);
                pkt.insert(pkt.size(), dlen[15:8]);
                pkt.insert(pkt.size(), dlen[7:0]);
            end
            else
            begin
                repeat (3) pkt.insert(pkt.size(), 8'($urandom_range(0, 255)));
                if (!wr)
                begin
                    pkt.insert(pkt.size(), 8'($urandom_range(0, 255)));
                    pkt.insert(pkt.size(), dlen[23:16]);
                    pkt.insert(pkt.size(), dlen[15:8]);
                    pkt.insert(pkt.size(), dlen[7:0]);
                end
            end
            crc = 8'd0;
            foreach (pkt[i]) crc = crc8_next(crc, pkt[i]);
            pkt.insert(pkt.size(), crc);
            if (cmd == wr)
            begin
                crc = 8'd0;
                for (int i = 0; i < dlen; i++)
                begin
                    pkt.insert(pkt.size(), 8'($urandom_range(0, 255)));
                    crc = crc8_next(crc, pkt[pkt.size() - 1]);
                end
                pkt.insert(pkt.size(), crc);
            end
            pos = $urandom_range(0, pkt.size() - 1);
            case (dmg)
                0: pkt[pos] = pkt[pos] ^ 8'($urandom_range(1, 255));
                1: while (pkt.size() > pos) void'(pkt.pop_back());
                2: repeat ($urandom_range(1, 4)) pkt.insert(pkt.size(), 8'($urandom_range(0, 255)));
                3: pkt[1] = 8'($urandom_range(0, 255));
                default: ;
            endcase
        end
        repeat (npath) send_char(8'($urandom_range(0, 31)), 1'b0, draw_gap(burst));
        foreach (pkt[i]) send_char(pkt[i], 1'b0, draw_gap(burst));
        send_char(8'($urandom_range(0, 255)), 1'b1, draw_gap(burst));
    endtask

    initial
    begin
        parse_out_t last;
        int         pkts;
        dir_row_t   rows [14];
        rows = '{
            // end right after reset: incomplete, all fields zero
            '{8'h00, 1'b1, 1'b1, rmap_pkg::KIND_SUMMARY, {3'd0, rmap_pkg::ST_INCOMPLETE, 122'd0}},
            // path-only packet at both path extremes
            '{8'h00, 1'b0, 1'b1, rmap_pkg::KIND_PATH,    128'h00},
            '{8'h1F, 1'b0, 1'b1, rmap_pkg::KIND_PATH,    128'h1F},
            '{8'hA5, 1'b1, 1'b1, rmap_pkg::KIND_SUMMARY, {3'd0, rmap_pkg::ST_INCOMPLETE, 122'd0}},
            // header shorter than four bytes
            '{8'hFF, 1'b0, 1'b0, rmap_pkg::KIND_PATH,    128'h0},
            '{8'h01, 1'b0, 1'b0, rmap_pkg::KIND_PATH,    128'h0},
            '{8'h00, 1'b1, 1'b0, rmap_pkg::KIND_SUMMARY, 128'h0},
            // write command with 12-byte reply address, cut short
            '{8'h20, 1'b0, 1'b0, rmap_pkg::KIND_PATH,    128'h0},
            '{8'h01, 1'b0, 1'b0, rmap_pkg::KIND_PATH,    128'h0},
            '{8'h7F, 1'b0, 1'b0, rmap_pkg::KIND_PATH,    128'h0},
            '{8'hFF, 1'b0, 1'b0, rmap_pkg::KIND_PATH,    128'h0},
            '{8'h00, 1'b0, 1'b0, rmap_pkg::KIND_PATH,    128'h0},
            '{8'h80, 1'b0, 1'b0, rmap_pkg::KIND_PATH,    128'h0},
            '{8'h00, 1'b1, 1'b0, rmap_pkg::KIND_SUMMARY, 128'h0}
        };
        errors      = 0;
        chars_sent  = 0;
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tlast     = 1'b0;
        clear_packet_state();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        foreach (rows[i])
        begin
            send_char(rows[i].b, rows[i].e, $urandom_range(0, 16));
            if (rows[i].chk)
            begin
                last = pending_results[pending_results.size() - 1];
                if (last.kind !== rows[i].kind || last.data !== rows[i].data)
                begin
                    $display("%0t: table row %0d expected %0d/%h predicted %0d/%h", $time, i,
                             rows[i].kind, rows[i].data, last.kind, last.data);
                    errors++;
                end
            end
        end

        // random packets
        pkts = 0;
        while (chars_sent < RANDOM_CHARS)
        begin
            if (pkts % 40 == 20)
            begin
                // drain all results before going on
                s_tvalid <= 1'b0;
                while (pending_results.size() != 0)
                    @(posedge clk);
                @(posedge clk);
            end
            send_packet((pkts % 10) < 2);
            pkts++;
        end
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- sim.f -----
design/rmap_pkg.sv
design/rmap_front.sv
design/rmap_queue.sv
design/rmap_packet_parser_top.sv
test/tb_rmap_packet_parser_top.sv
